[src/assert_macros.svh]
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant check failed");
`define AST_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
`define AST_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define AST_ALWAYS(lbl, clk, rst, expr)
`define AST_IMPL(lbl, clk, rst, ante, cons)
`define AST_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[src/scpr_pkg.sv]
package scpr_pkg;

  localparam int TRACE_DEPTH_DEF = 4096;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int WEIGHT_FRAC_DEF = 15;

  localparam int WEIGHT_BITS  = 18;
  localparam int NUM_CH       = 6;
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WEIGHT_XX  = 3'd0,
    REG_WEIGHT_YY  = 3'd1,
    REG_WEIGHT_ZZ  = 3'd2,
    REG_WEIGHT_XY  = 3'd3,
    REG_WEIGHT_XZ  = 3'd4,
    REG_WEIGHT_YZ  = 3'd5,
    REG_RESCALE_ON = 3'd6
  } cfg_reg_t;

endpackage

[src/six_channel_synthesis_peak_rescale.sv]
// Channel  Handshake               Beat contents
// in       in_valid / in_ready     op, g_xx..g_yz, observed, final_sample
// out      out_valid / out_ready   estimate, run_end, saturated, fault
// cfg      cfg_write (no wait)     cfg_index, cfg_data
//
// One item at a time. A load beat passes through product, two adder stages
// and finish. A drain beat runs through the bit-serial restoring divider;
// a drain with zero estimate peak skips the divider.
// Reset is synchronous, active high; the trace store is not cleared.
// A finished beat sits in the output register; the block accepts the next
// beat meanwhile and only holds in its finish state if that one is not taken.
`include "assert_macros.svh"

module six_channel_synthesis_peak_rescale #(
  parameter int TRACE_DEPTH = scpr_pkg::TRACE_DEPTH_DEF,
  parameter int SAMPLE_BITS = scpr_pkg::SAMPLE_BITS_DEF,
  parameter int WEIGHT_FRAC = scpr_pkg::WEIGHT_FRAC_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_write,
  input  logic [scpr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [scpr_pkg::WEIGHT_BITS-1:0]     cfg_data,
  // input beats
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 op,
  input  logic signed [SAMPLE_BITS-1:0]        g_xx,
  input  logic signed [SAMPLE_BITS-1:0]        g_yy,
  input  logic signed [SAMPLE_BITS-1:0]        g_zz,
  input  logic signed [SAMPLE_BITS-1:0]        g_xy,
  input  logic signed [SAMPLE_BITS-1:0]        g_xz,
  input  logic signed [SAMPLE_BITS-1:0]        g_yz,
  input  logic signed [SAMPLE_BITS-1:0]        observed,
  input  logic                                 final_sample,
  // result beats
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]        estimate,
  output logic                                 run_end,
  output logic                                 saturated,
  output logic                                 fault
);

  localparam int WB     = scpr_pkg::WEIGHT_BITS;
  localparam int NCH    = scpr_pkg::NUM_CH;
  localparam int PROD_W = SAMPLE_BITS + WB;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 3;
  localparam int CNT_W  = $clog2(TRACE_DEPTH + 1);
  localparam int ADDR_W = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;
  localparam int DIV_N  = 2 * SAMPLE_BITS;
  localparam int STEP_W = $clog2(DIV_N);

  localparam logic [CNT_W-1:0]       DEPTH_C   = CNT_W'(TRACE_DEPTH);
  localparam logic [STEP_W-1:0]      LAST_STEP = STEP_W'(DIV_N - 1);
  localparam logic [SAMPLE_BITS-1:0] SMAX      = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SMIN      = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  // largest quotient kept before the sign is applied: 2^(SAMPLE_BITS-1)
  localparam logic [DIV_N-1:0]       QLIM      = DIV_N'(SMIN);

  typedef enum logic [2:0] {
    S_IDLE, S_ADD1, S_ADD2, S_LFIN, S_RD, S_DIV, S_DFIN, S_EMPTY
  } state_t;

  state_t state;

  // configuration registers
  logic signed [WB-1:0] weight [NCH];
  logic                 rescale_on;

  // load datapath
  logic signed [SAMPLE_BITS-1:0] g_in [NCH];
  logic signed [PROD_W-1:0]      prod [NCH];
  logic signed [PAIR_W-1:0]      pair [3];
  logic signed [SUM_W-1:0]       sum;
  logic signed [SAMPLE_BITS-1:0] obs_hold;
  logic                          end_hold;

  // trace bookkeeping
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       rd_ptr;
  logic [SAMPLE_BITS-1:0] obs_peak;
  logic [SAMPLE_BITS-1:0] est_peak;
  logic                   trace_complete;

  // trace store, one write and one read port, registered read
  logic signed [SAMPLE_BITS-1:0] store [TRACE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic                          mem_we;
  logic                          mem_re;
  logic [ADDR_W-1:0]             mem_wa;
  logic [ADDR_W-1:0]             mem_ra;

  // divider
  logic [SAMPLE_BITS-1:0] rem;
  logic [DIV_N-1:0]       quo;
  logic [STEP_W-1:0]      step_cnt;
  logic                   neg_hold;

  // combinational helpers
  logic                          accept;
  logic                          out_free;
  logic                          out_load;
  logic signed [SUM_W-1:0]       shifted;
  logic                          fits;
  logic [SAMPLE_BITS-1:0]        est_c;
  logic                          sat_c;
  logic [CNT_W-1:0]              cnt_eff;
  logic [SAMPLE_BITS-1:0]        op_eff;
  logic [SAMPLE_BITS-1:0]        ep_eff;
  logic                          full;
  logic                          lfin_go;
  logic [SAMPLE_BITS-1:0]        om;
  logic [SAMPLE_BITS-1:0]        em;
  logic [SAMPLE_BITS-1:0]        rmag;
  logic [SAMPLE_BITS:0]          div_sh;
  logic [SAMPLE_BITS:0]          div_dv;
  logic                          div_ge;
  logic [SAMPLE_BITS:0]          div_diff;
  logic [SAMPLE_BITS-1:0]        q_c;
  logic [CNT_W-1:0]              rd_ptr_inc;

  assign g_in[0] = g_xx;
  assign g_in[1] = g_yy;
  assign g_in[2] = g_zz;
  assign g_in[3] = g_xy;
  assign g_in[4] = g_xz;
  assign g_in[5] = g_yz;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // arithmetic shift (floor), then clip to the sample range
  assign shifted = sum >>> WEIGHT_FRAC;
  assign fits    = (&shifted[SUM_W-1:SAMPLE_BITS-1]) || !(|shifted[SUM_W-1:SAMPLE_BITS-1]);
  assign est_c   = fits ? shifted[SAMPLE_BITS-1:0] : (shifted[SUM_W-1] ? SMIN : SMAX);
  assign sat_c   = !fits;

  // a buffered load after a completed trace starts a fresh one
  assign cnt_eff = trace_complete ? '0 : count;
  assign op_eff  = trace_complete ? '0 : obs_peak;
  assign ep_eff  = trace_complete ? '0 : est_peak;
  assign full    = (cnt_eff >= DEPTH_C);
  // overflow fault needs the output register; a plain store does not
  assign lfin_go = !full || out_free;

  // a new result beat enters the output register this cycle
  assign out_load = out_free &&
                    (((state == S_LFIN) && (!rescale_on || full)) ||
                     (state == S_DFIN) || (state == S_EMPTY));

  assign om = obs_hold[SAMPLE_BITS-1] ? (~obs_hold + 1'b1) : obs_hold;
  assign em = est_c[SAMPLE_BITS-1] ? (~est_c + 1'b1) : est_c;

  assign mem_we = (state == S_LFIN) && rescale_on && !full;
  assign mem_wa = cnt_eff[ADDR_W-1:0];
  assign mem_re = accept && op && (rd_ptr < count);
  assign mem_ra = rd_ptr[ADDR_W-1:0];

  assign rmag = rd_data[SAMPLE_BITS-1] ? (~rd_data + 1'b1) : rd_data;

  // one restoring step per cycle
  assign div_sh   = {rem, quo[DIV_N-1]};
  assign div_dv   = {1'b0, est_peak};
  assign div_ge   = (div_sh >= div_dv);
  assign div_diff = div_sh - div_dv;

  assign q_c        = (quo > QLIM) ? SMIN : quo[SAMPLE_BITS-1:0];
  assign rd_ptr_inc = rd_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCH; i++) begin
        weight[i] <= '0;
      end
      rescale_on <= 1'b0;
    end else if (cfg_write) begin
      unique case (scpr_pkg::cfg_reg_t'(cfg_index))
        scpr_pkg::REG_WEIGHT_XX:  weight[0] <= cfg_data;
        scpr_pkg::REG_WEIGHT_YY:  weight[1] <= cfg_data;
        scpr_pkg::REG_WEIGHT_ZZ:  weight[2] <= cfg_data;
        scpr_pkg::REG_WEIGHT_XY:  weight[3] <= cfg_data;
        scpr_pkg::REG_WEIGHT_XZ:  weight[4] <= cfg_data;
        scpr_pkg::REG_WEIGHT_YZ:  weight[5] <= cfg_data;
        scpr_pkg::REG_RESCALE_ON: rescale_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Store and drain never overlap: a drain read is issued only from idle,
  // after any earlier write has landed, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_wa] <= est_c;
    end
    if (mem_re) begin
      rd_data <= store[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      count          <= '0;
      rd_ptr         <= '0;
      obs_peak       <= '0;
      est_peak       <= '0;
      trace_complete <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (op) begin
              state <= (rd_ptr < count) ? S_RD : S_EMPTY;
            end else begin
              for (int i = 0; i < NCH; i++) begin
                prod[i] <= weight[i] * g_in[i];
              end
              obs_hold <= observed;
              end_hold <= final_sample;
              state    <= S_ADD1;
            end
          end
        end
        S_ADD1: begin
          for (int i = 0; i < 3; i++) begin
            pair[i] <= PAIR_W'(prod[2*i]) + PAIR_W'(prod[2*i+1]);
          end
          state <= S_ADD2;
        end
        S_ADD2: begin
          sum   <= SUM_W'(pair[0]) + SUM_W'(pair[1]) + SUM_W'(pair[2]);
          state <= S_LFIN;
        end
        S_LFIN: begin
          if (!rescale_on) begin
            // streaming: hand the estimate straight out
            if (out_free) begin
              out_valid <= 1'b1;
              estimate  <= est_c;
              run_end   <= end_hold;
              saturated <= sat_c;
              fault     <= 1'b0;
              state     <= S_IDLE;
            end
          end else if (lfin_go) begin
            trace_complete <= end_hold;
            rd_ptr         <= trace_complete ? '0 : rd_ptr;
            if (full) begin
              count     <= cnt_eff;
              obs_peak  <= op_eff;
              est_peak  <= ep_eff;
              out_valid <= 1'b1;
              estimate  <= '0;
              run_end   <= end_hold;
              saturated <= 1'b0;
              fault     <= 1'b1;
            end else begin
              count    <= cnt_eff + 1'b1;
              obs_peak <= (om > op_eff) ? om : op_eff;
              est_peak <= (em > ep_eff) ? em : ep_eff;
            end
            state <= S_IDLE;
          end
        end
        S_RD: begin
          // |stored| * observed peak, then divide by the estimate peak
          quo      <= (est_peak == '0) ? '0 : rmag * obs_peak;
          rem      <= '0;
          step_cnt <= '0;
          neg_hold <= rd_data[SAMPLE_BITS-1];
          state    <= (est_peak == '0) ? S_DFIN : S_DIV;
        end
        S_DIV: begin
          rem      <= div_ge ? div_diff[SAMPLE_BITS-1:0] : div_sh[SAMPLE_BITS-1:0];
          quo      <= {quo[DIV_N-2:0], div_ge};
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == LAST_STEP) begin
            state <= S_DFIN;
          end
        end
        S_DFIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            fault     <= 1'b0;
            run_end   <= trace_complete && (rd_ptr_inc == count);
            // only a positive full-scale quotient overflows
            if (!neg_hold && q_c[SAMPLE_BITS-1]) begin
              estimate  <= SMAX;
              saturated <= 1'b1;
            end else begin
              estimate  <= neg_hold ? (~q_c + 1'b1) : q_c;
              saturated <= 1'b0;
            end
            rd_ptr <= rd_ptr_inc;
            state  <= S_IDLE;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            out_valid <= 1'b1;
            estimate  <= '0;
            run_end   <= 1'b0;
            saturated <= 1'b0;
            fault     <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `AST_ALWAYS(a_count_bound, clk, rst, count <= DEPTH_C)
  `AST_ALWAYS(a_ptr_bound, clk, rst, rd_ptr <= count)
  `AST_NEXT(a_accept_leaves_idle, clk, rst, accept, state != S_IDLE)
  `AST_IMPL(a_fault_not_sat, clk, rst, out_valid, !(fault && saturated))
  `AST_IMPL(a_write_no_read, clk, rst, mem_we, !mem_re)

endmodule
